/* src/cdcnt_pkg.sv */
// Shared types, operation codes and calendar tables for the calendar date counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cdcnt_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 12;
    localparam int ORD_W    = 9;
    localparam int OP_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = YEAR_W;

    localparam logic [YEAR_W-1:0]  YEAR_LIMIT      = 12'd4095;
    localparam logic [YEAR_W-1:0]  RST_YEAR        = 12'd2022;
    localparam logic [YEAR_W-1:0]  RST_MIN_YEAR    = 12'd2022;
    localparam logic [YEAR_W-1:0]  RST_MAX_YEAR    = 12'd2050;
    localparam logic [DAY_W-1:0]   RST_DAY         = 5'd1;
    localparam logic [MONTH_W-1:0] RST_MONTH       = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC       = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST       = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST_DEC    = 5'd31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_NEXT       = 3'd0,
        OP_BACK       = 3'd1,
        OP_SET_MONTH  = 3'd2,
        OP_SET_DAY    = 3'd3,
        OP_LOAD       = 3'd4
    } t_op;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        t_date             date;
        logic [ORD_W-1:0]  ordinal;
        logic              rejected;
    } t_result;

    // Days in month, no leap years; codes outside 1..12 read as 31
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                       len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    // Days before the first of the month; codes outside 1..12 read as 0
    function automatic logic [ORD_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [ORD_W-1:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* src/cdcnt_step.sv */
// Next-date logic: applies one operation to the stored date and builds the result.
// Depends on cdcnt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdcnt_step (
    input  wire cdcnt_pkg::t_date                 i_cur,
    input  wire logic [cdcnt_pkg::OP_W-1:0]       i_operation,
    input  wire logic [cdcnt_pkg::MONTH_W-1:0]    i_new_month,
    input  wire logic [cdcnt_pkg::DAY_W-1:0]      i_new_day,
    input  wire logic [cdcnt_pkg::YEAR_W-1:0]     i_new_year,
    input  wire logic [cdcnt_pkg::YEAR_W-1:0]     i_min_year,
    input  wire logic [cdcnt_pkg::YEAR_W-1:0]     i_max_year,
    output cdcnt_pkg::t_date                      o_next,
    output cdcnt_pkg::t_result                    o_result
);
    import cdcnt_pkg::*;

    logic cur_year_ok;
    logic new_year_ok;
    logic set_month_ok;
    logic set_day_ok;
    logic load_ok;
    logic rej;
    t_date nxt;

    assign cur_year_ok = (i_cur.year >= i_min_year) && (i_cur.year <= i_max_year);
    assign new_year_ok = (i_new_year >= i_min_year) && (i_new_year <= i_max_year);

    assign set_month_ok = cur_year_ok
                       && (i_new_month >= MONTH_JAN) && (i_new_month <= MONTH_DEC)
                       && (i_cur.day >= DAY_FIRST) && (i_cur.day <= month_len(i_new_month));
    assign set_day_ok   = cur_year_ok
                       && (i_cur.month >= MONTH_JAN) && (i_cur.month <= MONTH_DEC)
                       && (i_new_day >= DAY_FIRST) && (i_new_day <= month_len(i_cur.month));
    assign load_ok      = new_year_ok
                       && (i_new_month >= MONTH_JAN) && (i_new_month <= MONTH_DEC)
                       && (i_new_day >= DAY_FIRST) && (i_new_day <= month_len(i_new_month));

    always_comb begin
        nxt = i_cur;
        rej = 1'b0;
        case (i_operation)
            OP_NEXT: begin
                if (i_cur.month == MONTH_DEC && i_cur.day == DAY_LAST_DEC) begin
                    nxt.day   = DAY_FIRST;
                    nxt.month = MONTH_JAN;
                    if (i_cur.year != YEAR_LIMIT) begin
                        nxt.year = i_cur.year + 12'd1;
                    end
                end else if (i_cur.day >= month_len(i_cur.month)) begin
                    nxt.day   = DAY_FIRST;
                    nxt.month = i_cur.month + 4'd1;
                end else begin
                    nxt.day = i_cur.day + 5'd1;
                end
            end
            OP_BACK: begin
                if (i_cur.month == MONTH_JAN && i_cur.day == DAY_FIRST) begin
                    nxt.day   = DAY_LAST_DEC;
                    nxt.month = MONTH_DEC;
                    if (i_cur.year != '0) begin
                        nxt.year = i_cur.year - 12'd1;
                    end
                end else if (i_cur.day <= DAY_FIRST) begin
                    nxt.month = i_cur.month - 4'd1;
                    nxt.day   = month_len(i_cur.month - 4'd1);
                end else begin
                    nxt.day = i_cur.day - 5'd1;
                end
            end
            OP_SET_MONTH: begin
                if (set_month_ok) begin
                    nxt.month = i_new_month;
                end else begin
                    rej = 1'b1;
                end
            end
            OP_SET_DAY: begin
                if (set_day_ok) begin
                    nxt.day = i_new_day;
                end else begin
                    rej = 1'b1;
                end
            end
            OP_LOAD: begin
                if (load_ok) begin
                    nxt.month = i_new_month;
                    nxt.day   = i_new_day;
                    nxt.year  = i_new_year;
                end else begin
                    rej = 1'b1;
                end
            end
            default: begin
                // unused codes leave the date alone
                nxt = i_cur;
            end
        endcase
    end

    assign o_next            = nxt;
    assign o_result.date     = nxt;
    assign o_result.ordinal  = days_before(nxt.month) + {{(ORD_W-DAY_W){1'b0}}, nxt.day};
    assign o_result.rejected = rej;

endmodule

`default_nettype wire

/* src/cdcnt_obuf.sv */
// Two-entry result buffer (output register plus skid) with valid/stall on both sides.
// Depends on cdcnt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdcnt_obuf (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire cdcnt_pkg::t_result  i_data,
    output logic                     o_full,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output cdcnt_pkg::t_result       o_data
);
    import cdcnt_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;
    logic    out_free;

    assign pop      = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_push;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= i_data;
            end else begin
                r_out  <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

/* src/calendar_date_up_down_counter_core.sv */
// Each accepted result is registered in the two-entry result buffer. Throughput: one
// transaction per cycle while o_in_stall is low; the date registers close a loop
// through the next-date logic, and the result buffer absorbs output stalls.
// Reset (synchronous, active low): date 1/1/2022, year window 2022..2050, buffer empty.
// Depends on cdcnt_pkg, cdcnt_step, cdcnt_obuf.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_up_down_counter_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [cdcnt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [cdcnt_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [cdcnt_pkg::OP_W-1:0]            i_operation,
    input  wire logic [cdcnt_pkg::MONTH_W-1:0]         i_new_month,
    input  wire logic [cdcnt_pkg::DAY_W-1:0]           i_new_day,
    input  wire logic [cdcnt_pkg::YEAR_W-1:0]          i_new_year,
    // output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [cdcnt_pkg::DAY_W-1:0]                o_cur_day,
    output logic [cdcnt_pkg::MONTH_W-1:0]              o_cur_month,
    output logic [cdcnt_pkg::YEAR_W-1:0]               o_cur_year,
    output logic [cdcnt_pkg::ORD_W-1:0]                o_ordinal_day,
    output logic                                       o_rejected
);
    import cdcnt_pkg::*;

    logic [YEAR_W-1:0] r_min_year;
    logic [YEAR_W-1:0] r_max_year;
    t_date             r_date;
    t_date             n_date;
    t_result           step_res;
    t_result           out_res;
    logic              buf_full;
    logic              accept;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= RST_MIN_YEAR;
            r_max_year <= RST_MAX_YEAR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_YEAR: r_min_year <= i_cfg_wdata;
                CFG_MAX_YEAR: r_max_year <= i_cfg_wdata;
                default:      r_min_year <= r_min_year;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_date.day   <= RST_DAY;
            r_date.month <= RST_MONTH;
            r_date.year  <= RST_YEAR;
        end else if (accept) begin
            r_date <= n_date;
        end
    end

    cdcnt_step u_step (
        .i_cur       (r_date),
        .i_operation (i_operation),
        .i_new_month (i_new_month),
        .i_new_day   (i_new_day),
        .i_new_year  (i_new_year),
        .i_min_year  (r_min_year),
        .i_max_year  (r_max_year),
        .o_next      (n_date),
        .o_result    (step_res)
    );

    cdcnt_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (step_res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_cur_day     = out_res.date.day;
    assign o_cur_month   = out_res.date.month;
    assign o_cur_year    = out_res.date.year;
    assign o_ordinal_day = out_res.ordinal;
    assign o_rejected    = out_res.rejected;

    // stored date is always a real calendar date
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_date.month >= MONTH_JAN) && (r_date.month <= MONTH_DEC))
        else $error("stored month out of range");

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_date.day >= DAY_FIRST) && (r_date.day <= month_len(r_date.month)))
        else $error("stored day out of range for month");

    // skid entry is only occupied behind a held output entry
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_full |-> o_out_valid)
        else $error("skid entry valid with empty output register");

    // after an accepted transaction, the output register always holds a valid result
    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted transaction did not produce a result");

endmodule

`default_nettype wire
